/* hdl/periodic_task_dispatcher_defines.svh */
// Assertion macros for the periodic task dispatcher.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef PERIODIC_TASK_DISPATCHER_DEFINES_SVH
`define PERIODIC_TASK_DISPATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define PDT_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PDT_NEVER(lbl, clock, reset, expr, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define PDT_ASSERT(lbl, clock, reset, prop, msg)
`define PDT_NEVER(lbl, clock, reset, expr, msg)
`endif
`endif

/* hdl/pdt_pkg.sv */
// Types, codes and helper function of the periodic task dispatcher.
// Used by the register block, the task cells and the top level.
package pdt_pkg;

  localparam int TIME_W = 48;
  localparam int SLOT_W = 3;
  localparam int KEY_W  = TIME_W + 1;
  localparam int ADDR_W = 4;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_ADD      = 3'd1;
  localparam logic [2:0] OP_REMOVE   = 3'd2;
  localparam logic [2:0] OP_UPDATE   = 3'd3;
  localparam logic [2:0] OP_COMPLETE = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;

  localparam logic [1:0] POL_RR       = 2'd0;
  localparam logic [1:0] POL_PRIORITY = 2'd1;
  localparam logic [1:0] POL_DEADLINE = 2'd2;
  localparam logic [1:0] POL_PERIOD   = 2'd3;

  localparam logic [1:0] REG_POLICY  = 2'd0;
  localparam logic [1:0] REG_LIMIT   = 2'd1;
  localparam logic [1:0] REG_BACKOFF = 2'd2;

  typedef struct packed {
    logic [1:0]  policy;
    logic [7:0]  failure_limit;
    logic [31:0] backoff_time;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] start_time;
    logic [31:0]       period;
    logic [31:0]       deadline_span;
    logic [2:0]        priority_level;
    logic              failed;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [SLOT_W:0]   rr_start;
    logic              best_found;
    logic [SLOT_W-1:0] best_slot;
    logic [KEY_W-1:0]  best_key;
    logic              rr_found;
    logic [SLOT_W-1:0] rr_slot;
    logic              hit;
    logic [1:0]        status;
    logic              deactivated;
    logic              deadline_missed;
  } wave_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [31:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W + 1 - 32){1'b0}}, d};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

/* hdl/pdt_regs.sv */
// APB configuration registers of the periodic task dispatcher.
// Depends on pdt_pkg for the register codes and the configuration struct.
module pdt_regs
  import pdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy        <= POL_RR;
      cfg.failure_limit <= 8'd10;
      cfg.backoff_time  <= 32'd100000;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        REG_POLICY:  cfg.policy        <= pwdata[1:0];
        REG_LIMIT:   cfg.failure_limit <= pwdata[7:0];
        REG_BACKOFF: cfg.backoff_time  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_POLICY:  prdata = {30'd0, cfg.policy};
      REG_LIMIT:   prdata = {24'd0, cfg.failure_limit};
      REG_BACKOFF: prdata = cfg.backoff_time;
      default:     prdata = 32'd0;
    endcase
  end

endmodule

/* hdl/pdt_cell.sv */
// One task slot of the dispatcher chain: holds the slot's task state and
// folds it into the transaction passing by. Depends on pdt_pkg.
module pdt_cell
  import pdt_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  wave_t wave_in,
  output wave_t wave_out
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic              used, active;
  logic [31:0]       period, deadline;
  logic [2:0]        prio;
  logic [TIME_W-1:0] next_due, last_run, react_at;
  logic [7:0]        fail_count;

  logic              used_next, active_next;
  logic [31:0]       period_next, deadline_next;
  logic [2:0]        prio_next;
  logic [TIME_W-1:0] next_due_next, last_run_next, react_at_next;
  logic [7:0]        fail_count_next;
  wave_t             wave_next;

  logic              hit, ready;
  logic [KEY_W-1:0]  abs_dl, key, abs_new;
  logic [TIME_W-1:0] nd_new;
  logic [7:0]        fc_inc;

  always_comb begin
    used_next       = used;
    active_next     = active;
    period_next     = period;
    deadline_next   = deadline;
    prio_next       = prio;
    next_due_next   = next_due;
    last_run_next   = last_run;
    react_at_next   = react_at;
    fail_count_next = fail_count;
    wave_next       = wave_in;

    hit    = wave_in.valid && (wave_in.cmd.slot == MY_SLOT);
    ready  = used && active && (wave_in.cmd.now_time >= next_due);
    abs_dl = {1'b0, next_due} + {{(KEY_W - 32){1'b0}}, deadline};
    case (cfg.policy)
      POL_PRIORITY: key = {{(KEY_W - 3){1'b0}}, prio};
      POL_DEADLINE: key = abs_dl;
      POL_PERIOD:   key = {{(KEY_W - 32){1'b0}}, period};
      default:      key = '0;
    endcase
    nd_new  = sat_add(wave_in.cmd.start_time, period);
    abs_new = {1'b0, nd_new} + {{(KEY_W - 32){1'b0}}, deadline};
    fc_inc  = (fail_count == 8'hFF) ? fail_count : fail_count + 8'd1;

    if (wave_in.valid && wave_in.cmd.opcode == OP_TICK) begin
      if (ready && (!wave_in.best_found || key < wave_in.best_key)) begin
        wave_next.best_found = 1'b1;
        wave_next.best_slot  = MY_SLOT;
        wave_next.best_key   = key;
      end
      if (ready && !wave_in.rr_found && {1'b0, MY_SLOT} >= wave_in.rr_start) begin
        wave_next.rr_found = 1'b1;
        wave_next.rr_slot  = MY_SLOT;
      end
      if (used && !active && fail_count != 8'd0 && wave_in.cmd.now_time >= react_at) begin
        active_next     = 1'b1;
        fail_count_next = 8'd0;
      end
    end

    if (hit) begin
      wave_next.hit = 1'b1;
      case (wave_in.cmd.opcode)
        OP_ADD: begin
          if (used) begin
            wave_next.status = ST_OCCUPIED;
          end else begin
            used_next       = 1'b1;
            active_next     = 1'b1;
            period_next     = wave_in.cmd.period;
            deadline_next   = wave_in.cmd.deadline_span;
            prio_next       = wave_in.cmd.priority_level;
            next_due_next   = sat_add(wave_in.cmd.now_time, wave_in.cmd.period);
            last_run_next   = wave_in.cmd.now_time;
            fail_count_next = 8'd0;
            react_at_next   = '0;
          end
        end
        OP_REMOVE: begin
          if (!used) begin
            wave_next.status = ST_EMPTY;
          end else begin
            used_next   = 1'b0;
            active_next = 1'b0;
          end
        end
        OP_UPDATE: begin
          if (!used) begin
            wave_next.status = ST_EMPTY;
          end else begin
            period_next   = wave_in.cmd.period;
            deadline_next = wave_in.cmd.deadline_span;
            prio_next     = wave_in.cmd.priority_level;
            next_due_next = sat_add(last_run, wave_in.cmd.period);
          end
        end
        OP_COMPLETE: begin
          if (!used) begin
            wave_next.status = ST_EMPTY;
          end else if (!wave_in.cmd.failed) begin
            last_run_next   = wave_in.cmd.start_time;
            next_due_next   = nd_new;
            fail_count_next = 8'd0;
            wave_next.deadline_missed = !abs_new[KEY_W-1] &&
                                        (wave_in.cmd.now_time > abs_new[TIME_W-1:0]);
          end else begin
            fail_count_next = fc_inc;
            if (fc_inc >= cfg.failure_limit) begin
              active_next           = 1'b0;
              react_at_next         = sat_add(wave_in.cmd.now_time, cfg.backoff_time);
              wave_next.deactivated = 1'b1;
            end
            wave_next.deadline_missed = !abs_dl[KEY_W-1] &&
                                        (wave_in.cmd.now_time > abs_dl[TIME_W-1:0]);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= 1'b0;
      active         <= 1'b0;
      wave_out.valid <= 1'b0;
    end else begin
      used     <= used_next;
      active   <= active_next;
      wave_out <= wave_next;
    end
  end

  always_ff @(posedge clk) begin
    period     <= period_next;
    deadline   <= deadline_next;
    prio       <= prio_next;
    next_due   <= next_due_next;
    last_run   <= last_run_next;
    react_at   <= react_at_next;
    fail_count <= fail_count_next;
  end

endmodule

/* hdl/periodic_task_dispatcher.sv */
// Top level of the periodic task dispatcher: input register, chain of task
// cells, result holding and output registers. Depends on pdt_pkg, pdt_regs
// and pdt_cell.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   opcode .. failed
//   out       output     out_valid / out_stall chosen_slot .. deadline_missed
//   apb       input      psel/penable/pready   paddr, pwdata, prdata
//
// Each transaction passes from acceptance through the input register, one
// register in each cell as it travels the chain of task cells and the result
// holding register to the output register.
// One transaction is in flight at a time; in_stall is high until its result
// reaches the output register, so a new transaction is taken only after the
// previous one's result has reached it. Reset clears the table. A stalled
// result holds the output and the transaction behind it.
`include "periodic_task_dispatcher_defines.svh"
module periodic_task_dispatcher
  import pdt_pkg::*;
#(
  parameter int TASK_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic [2:0]        slot,
  input  logic [47:0]       now_time,
  input  logic [47:0]       start_time,
  input  logic [31:0]       period,
  input  logic [31:0]       deadline_span,
  input  logic [2:0]        priority_level,
  input  logic              failed,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        chosen_slot,
  output logic              chosen_valid,
  output logic [1:0]        status,
  output logic              deactivated,
  output logic              deadline_missed,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t              cfg;
  wave_t             head;
  wave_t             waves [0:TASK_SLOTS];
  logic [TASK_SLOTS:0] wave_valids;
  wave_t             done;
  logic              busy;
  logic [SLOT_W-1:0] rr_last;
  logic              rr_last_valid;
  logic              accept, load_out;
  logic              op_known;
  logic              tick_found;
  logic [SLOT_W-1:0] pick;

  pdt_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign waves[0] = head;

  for (genvar k = 0; k < TASK_SLOTS; k++) begin : g_cell
    pdt_cell #(.IDX(k)) u_cell (
      .clk(clk), .rst(rst), .cfg(cfg), .wave_in(waves[k]), .wave_out(waves[k+1])
    );
  end

  for (genvar k = 0; k <= TASK_SLOTS; k++) begin : g_valid
    assign wave_valids[k] = waves[k].valid;
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;
  assign load_out = done.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else begin
      head.valid <= accept;
    end
    head.cmd.opcode         <= opcode;
    head.cmd.slot           <= slot;
    head.cmd.now_time       <= now_time;
    head.cmd.start_time     <= start_time;
    head.cmd.period         <= period;
    head.cmd.deadline_span  <= deadline_span;
    head.cmd.priority_level <= priority_level;
    head.cmd.failed         <= failed;
    head.rr_start           <= rr_last_valid ? {1'b0, rr_last} + 1'b1 : '0;
    head.best_found         <= 1'b0;
    head.best_slot          <= '0;
    head.best_key           <= '0;
    head.rr_found           <= 1'b0;
    head.rr_slot            <= '0;
    head.hit                <= 1'b0;
    head.status             <= ST_OK;
    head.deactivated        <= 1'b0;
    head.deadline_missed    <= 1'b0;
  end

  always_comb begin
    case (done.cmd.opcode)
      OP_ADD, OP_REMOVE, OP_UPDATE, OP_COMPLETE: op_known = 1'b1;
      default:                                  op_known = 1'b0;
    endcase
    tick_found = (done.cmd.opcode == OP_TICK) && done.best_found;
    pick       = done.rr_found ? done.rr_slot : done.best_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      done.valid    <= 1'b0;
      out_valid     <= 1'b0;
      rr_last       <= '0;
      rr_last_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (load_out) begin
        busy <= 1'b0;
      end
      if (waves[TASK_SLOTS].valid) begin
        done <= waves[TASK_SLOTS];
      end else if (load_out) begin
        done.valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        if (tick_found && cfg.policy == POL_RR) begin
          rr_last       <= pick;
          rr_last_valid <= 1'b1;
        end else if (done.cmd.opcode == OP_REMOVE && done.hit &&
                     done.status == ST_OK && done.cmd.slot == rr_last) begin
          rr_last_valid <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      chosen_valid    <= tick_found;
      chosen_slot     <= tick_found ? (cfg.policy == POL_RR ? pick : done.best_slot) : '0;
      status          <= (op_known && !done.hit) ? ST_EMPTY : done.status;
      deactivated     <= done.deactivated;
      deadline_missed <= done.deadline_missed;
    end
  end

  `PDT_ASSERT(a_chain_onehot, clk, rst, $onehot0(wave_valids), "more than one transaction in chain")
  `PDT_ASSERT(a_chain_busy, clk, rst, (wave_valids != '0) |-> busy, "chain active while idle")
  `PDT_ASSERT(a_done_busy, clk, rst, done.valid |-> busy, "held result while idle")

endmodule

/* bench/periodic_task_dispatcher_tb.sv */
// Self-checking testbench for the periodic task dispatcher: the task table
// operations, all four pick policies, failure backoff and deadline flags.
// Depends on pdt_pkg and the periodic_task_dispatcher RTL.
`timescale 1ns / 100ps
module periodic_task_dispatcher_tb
  import pdt_pkg::*;
();

  localparam int SLOTS = 8;
  localparam int SETTLE = SLOTS + 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [47:0] TIME_MAX = {48{1'b1}};

  typedef struct packed {
    logic [2:0] chosen_slot;
    logic       chosen_valid;
    logic [1:0] status;
    logic       deactivated;
    logic       deadline_missed;
  } dispatch_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode = '0;
  logic [2:0]  slot = '0;
  logic [47:0] now_time = '0;
  logic [47:0] start_time = '0;
  logic [31:0] period = '0;
  logic [31:0] deadline_span = '0;
  logic [2:0]  priority_level = '0;
  logic        failed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  chosen_slot;
  logic        chosen_valid;
  logic [1:0]  status;
  logic        deactivated;
  logic        deadline_missed;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  periodic_task_dispatcher #(.TASK_SLOTS(SLOTS)) DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the task table and registers.
  logic [1:0]  sh_policy;
  logic [7:0]  sh_limit;
  logic [31:0] sh_backoff;
  logic        sh_used [SLOTS];
  logic        sh_active [SLOTS];
  logic [31:0] sh_period [SLOTS];
  logic [31:0] sh_deadline [SLOTS];
  logic [2:0]  sh_prio [SLOTS];
  logic [47:0] sh_due [SLOTS];
  logic [47:0] sh_last [SLOTS];
  logic [7:0]  sh_fails [SLOTS];
  logic [47:0] sh_wake [SLOTS];
  logic [2:0]  sh_rr_last;
  logic        sh_rr_valid;

  dispatch_t pending_q[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  logic [47:0] clock_now = '0;

  function automatic logic [47:0] add_clamped(logic [47:0] t, logic [31:0] d);
    logic [48:0] s;
    s = {1'b0, t} + {17'd0, d};
    return s[48] ? TIME_MAX : s[47:0];
  endfunction

  function automatic logic [48:0] abs_deadline(int i);
    return {1'b0, sh_due[i]} + {17'd0, sh_deadline[i]};
  endfunction

  function automatic logic is_ready(int i, logic [47:0] now);
    return sh_used[i] && sh_active[i] && now >= sh_due[i];
  endfunction

  function automatic dispatch_t predict_dispatch(logic [2:0] op, logic [2:0] s,
      logic [47:0] now, logic [47:0] st, logic [31:0] per, logic [31:0] dl,
      logic [2:0] prio, logic fl);
    dispatch_t r;
    logic [2:0] idx;
    logic better;
    int best;
    r = '0;
    case (op)
      OP_TICK: begin
        if (sh_policy == POL_RR) begin
          idx = sh_rr_valid ? sh_rr_last + 3'd1 : 3'd0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!r.chosen_valid && is_ready(idx, now)) begin
              r.chosen_valid = 1'b1;
              r.chosen_slot = idx;
              sh_rr_last = idx;
              sh_rr_valid = 1'b1;
            end
            idx = idx + 3'd1;
          end
        end else begin
          best = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (is_ready(i, now)) begin
              if (!r.chosen_valid) better = 1'b1;
              else if (sh_policy == POL_PRIORITY) better = sh_prio[i] < sh_prio[best];
              else if (sh_policy == POL_DEADLINE) better = abs_deadline(i) < abs_deadline(best);
              else better = sh_period[i] < sh_period[best];
              if (better) begin
                best = i;
                r.chosen_valid = 1'b1;
              end
            end
          end
          if (r.chosen_valid) r.chosen_slot = best[2:0];
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (sh_used[i] && !sh_active[i] && sh_fails[i] > 0 && now >= sh_wake[i]) begin
            sh_active[i] = 1'b1;
            sh_fails[i] = '0;
          end
        end
      end
      OP_ADD: begin
        if (sh_used[s]) begin
          r.status = ST_OCCUPIED;
        end else begin
          sh_used[s] = 1'b1;
          sh_active[s] = 1'b1;
          sh_period[s] = per;
          sh_deadline[s] = dl;
          sh_prio[s] = prio;
          sh_due[s] = add_clamped(now, per);
          sh_last[s] = now;
          sh_fails[s] = '0;
          sh_wake[s] = '0;
        end
      end
      OP_REMOVE, OP_UPDATE, OP_COMPLETE: begin
        if (!sh_used[s]) begin
          r.status = ST_EMPTY;
        end else if (op == OP_REMOVE) begin
          sh_used[s] = 1'b0;
          sh_active[s] = 1'b0;
          if (sh_rr_valid && sh_rr_last == s) sh_rr_valid = 1'b0;
        end else if (op == OP_UPDATE) begin
          sh_period[s] = per;
          sh_deadline[s] = dl;
          sh_prio[s] = prio;
          sh_due[s] = add_clamped(sh_last[s], per);
        end else begin
          if (!fl) begin
            sh_last[s] = st;
            sh_due[s] = add_clamped(st, sh_period[s]);
            sh_fails[s] = '0;
          end else begin
            if (sh_fails[s] != 8'hFF) sh_fails[s] = sh_fails[s] + 8'd1;
            if (sh_fails[s] >= sh_limit) begin
              sh_active[s] = 1'b0;
              sh_wake[s] = add_clamped(now, sh_backoff);
              r.deactivated = 1'b1;
            end
          end
          r.deadline_missed = {1'b0, now} > abs_deadline(s);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Result side: random stall, long hold-offs on request, and the checker.
  always @(posedge clk) begin
    dispatch_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        errors = errors + 1;
      end else begin
        e = pending_q.pop_front();
        checked <= checked + 1;
        if (chosen_slot !== e.chosen_slot) begin
          $error("chosen_slot expected %0d actual %0d", e.chosen_slot, chosen_slot);
          errors = errors + 1;
        end
        if (chosen_valid !== e.chosen_valid) begin
          $error("chosen_valid expected %0d actual %0d", e.chosen_valid, chosen_valid);
          errors = errors + 1;
        end
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors = errors + 1;
        end
        if (deactivated !== e.deactivated) begin
          $error("deactivated expected %0d actual %0d", e.deactivated, deactivated);
          errors = errors + 1;
        end
        if (deadline_missed !== e.deadline_missed) begin
          $error("deadline_missed expected %0d actual %0d", e.deadline_missed,
                 deadline_missed);
          errors = errors + 1;
        end
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < recv_idle;
    end
  end

  task automatic send_cmd(logic [2:0] op, logic [2:0] s, logic [47:0] now,
      logic [47:0] st, logic [31:0] per, logic [31:0] dl, logic [2:0] prio,
      logic fl);
    if (in_valid && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    opcode <= op;
    slot <= s;
    now_time <= now;
    start_time <= st;
    period <= per;
    deadline_span <= dl;
    priority_level <= prio;
    failed <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.insert(pending_q.size(), predict_dispatch(op, s, now, st, per, dl, prio, fl));
    accepted++;
  endtask

  task automatic drain_results();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POLICY: sh_policy = val[1:0];
      REG_LIMIT: sh_limit = val[7:0];
      default: sh_backoff = val;
    endcase
  endtask

  task automatic send_random_cmd();
    int pick;
    logic [47:0] now;
    logic [47:0] st;
    logic [31:0] per;
    logic [31:0] dl;
    pick = $urandom_range(99);
    clock_now = clock_now + 48'($urandom_range(6));
    now = clock_now;
    per = $urandom_range(40);
    dl = $urandom_range(30);
    if ($urandom_range(19) == 0) now = 48'({$urandom(), $urandom()});
    if ($urandom_range(29) == 0) now = TIME_MAX - 48'($urandom_range(3));
    if ($urandom_range(19) == 0) per = $urandom();
    if ($urandom_range(19) == 0) dl = $urandom();
    st = now - 48'($urandom_range(20));
    if ($urandom_range(29) == 0) st = 48'({$urandom(), $urandom()});
    send_cmd(pick < 40 ? OP_TICK : pick < 54 ? OP_ADD : pick < 62 ? OP_REMOVE :
             pick < 70 ? OP_UPDATE : pick < 97 ? OP_COMPLETE : 3'($urandom_range(5, 7)),
             3'($urandom_range(7)), now, st, per, dl, 3'($urandom_range(7)),
             1'($urandom_range(1)));
  endtask

  task automatic test_directed();
    send_cmd(OP_ADD, 3'd0, 48'd0, 48'd0, 32'd10, 32'd5, 3'd5, 1'b0);
    send_cmd(OP_ADD, 3'd0, 48'd1, 48'd0, 32'd10, 32'd5, 3'd0, 1'b0);
    send_cmd(OP_REMOVE, 3'd3, 48'd1, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(OP_UPDATE, 3'd3, 48'd1, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(OP_COMPLETE, 3'd3, 48'd1, 48'd0, 32'd0, 32'd0, 3'd0, 1'b1);
    send_cmd(OP_ADD, 3'd7, TIME_MAX, TIME_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_cmd(OP_ADD, 3'd1, 48'd0, 48'd0, 32'd4, 32'd2, 3'd0, 1'b0);
    send_cmd(OP_TICK, 3'd0, 48'd9, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(OP_TICK, 3'd0, 48'd20, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(OP_TICK, 3'd0, 48'd20, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(OP_TICK, 3'd0, TIME_MAX, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(OP_REMOVE, 3'd7, 48'd20, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(OP_TICK, 3'd0, 48'd21, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(OP_COMPLETE, 3'd0, 48'd100, 48'd25, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(OP_COMPLETE, 3'd0, 48'd36, 48'd25, 32'd0, 32'd0, 3'd0, 1'b1);
    send_cmd(OP_UPDATE, 3'd1, 48'd40, 48'd0, 32'd0, 32'd0, 3'd3, 1'b0);
    send_cmd(OP_COMPLETE, 3'd1, 48'd40, 48'd30, 32'd0, 32'd0, 3'd0, 1'b0);
    send_cmd(3'd5, 3'd2, 48'd41, 48'd0, 32'd1, 32'd1, 3'd1, 1'b1);
    send_cmd(3'd7, 3'd7, 48'd41, 48'd0, 32'd1, 32'd1, 3'd1, 1'b1);
    drain_results();
  endtask

  task automatic test_backoff();
    write_reg(REG_LIMIT, 32'd1);
    write_reg(REG_BACKOFF, 32'd0);
    send_cmd(OP_ADD, 3'd2, clock_now, 48'd0, 32'd3, 32'd1, 3'd2, 1'b0);
    send_cmd(OP_COMPLETE, 3'd2, clock_now + 5, clock_now, 32'd0, 32'd0, 3'd0, 1'b1);
    send_cmd(OP_TICK, 3'd0, clock_now + 6, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    write_reg(REG_LIMIT, 32'd0);
    write_reg(REG_BACKOFF, 32'hFFFF_FFFF);
    send_cmd(OP_COMPLETE, 3'd2, TIME_MAX, clock_now, 32'd0, 32'd0, 3'd0, 1'b1);
    send_cmd(OP_TICK, 3'd0, TIME_MAX, 48'd0, 32'd0, 32'd0, 3'd0, 1'b0);
    write_reg(REG_LIMIT, 32'd255);
    for (int i = 0; i < 4; i++)
      send_cmd(OP_COMPLETE, 3'd2, clock_now, clock_now, 32'd0, 32'd0, 3'd0, 1'b1);
    drain_results();
  endtask

  task automatic test_policy_phase(logic [1:0] pol, int count);
    write_reg(REG_POLICY, {30'd0, pol});
    write_reg(REG_LIMIT, $urandom_range(1, 3));
    write_reg(REG_BACKOFF, $urandom_range(30));
    for (int i = 0; i < count; i++) send_random_cmd();
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_req++;
    for (int i = 0; i < 30; i++) send_random_cmd();
    drain_results();
  endtask

  task automatic test_pause_then_burst();
    for (int i = 0; i < 40; i++) begin
      send_random_cmd();
      if (i % 10 == 9) drain_results();
    end
    drain_results();
  endtask

  initial begin
    foreach (sh_used[i]) begin
      sh_used[i] = 1'b0;
      sh_active[i] = 1'b0;
      sh_fails[i] = '0;
    end
    sh_policy = POL_RR;
    sh_limit = 8'd10;
    sh_backoff = 32'd100000;
    sh_rr_last = '0;
    sh_rr_valid = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    send_idle = 7;
    recv_idle = 82;
    test_directed();
    test_backoff();
    test_policy_phase(POL_RR, 150);
    test_policy_phase(POL_PRIORITY, 150);
    test_backpressure();
    send_idle = 82;
    recv_idle = 7;
    test_policy_phase(POL_DEADLINE, 150);
    test_policy_phase(POL_PERIOD, 150);
    test_pause_then_burst();
    send_idle = 0;
    recv_idle = 0;
    test_policy_phase(POL_RR, 100);
    test_policy_phase(POL_PERIOD, 100);
    drain_results();
    $display("Covered %0d transactions (%0d results checked) across all four policies,",
             accepted, checked);
    $display("failure backoff, saturation at the time limit and long output hold-offs.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/pdt_pkg.sv
hdl/pdt_regs.sv
hdl/pdt_cell.sv
hdl/periodic_task_dispatcher.sv
bench/periodic_task_dispatcher_tb.sv
